>>> hdl/bpa_pkg.sv
// Shared widths, command codes and controller/datapath interface types.
package bpa_pkg;

   localparam int PAGE_W                = 12;
   localparam int LIMIT_W               = 13;
   localparam int CMD_W                 = 2;
   localparam int NUM_PAGES_DEFAULT     = 4096;
   localparam int MAP_WORD_BITS_DEFAULT = 64;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd2;

   typedef struct packed {
      logic clr_step;     // write an all-used row at the word counter, advance
      logic load_req;     // capture the request, restart counters
      logic rd_en;        // read a map row
      logic rd_next;      // read row at word counter + 1 instead of the counter
      logic scan_adv;     // skip a full row
      logic scan_capture; // hold a row with a free bit
      logic wr_hit;       // write back row with the found bit set
      logic wr_fr;        // write back row with the page bit set or cleared
      logic res_echo;
      logic res_fail;
      logic res_hit;
      logic out_load;     // move result to the response register
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic base_ge_lim;
      logic word_full;
      logic p_ge_lim;
      logic page_oob;
      logic rsp_free;
   } dp_status_type;

endpackage

>>> hdl/bitmap_page_allocator_top.sv
// Bitmap page frame allocator: top level joining sequencer and datapath.
//
// Requests arrive on req_* (valid/ready): req_cmd selects allocate, free or
// reserve, req_page names the page for free/reserve. Each request yields one
// transfer on rsp_*: the allocated page (or the echoed page) and a status bit
// that is set when no free page exists below the page limit.
// csr_wr_en/csr_wr_data write the page limit; write it only while idle.
// One request is worked at a time. Allocate reads one map row per cycle,
// examining up to the limit divided by MAP_WORD_BITS rows (64 rows by
// default) before it reports the found page or a failure.
// Free and reserve take the row and bit straight from the page number
// (MAP_WORD_BITS is a power of two) and read-modify-write the row; a page
// at or above NUM_PAGES is only echoed. Other codes are echoed too.
// req_ready returns in the cycle after the response is loaded.
// The result sits in an output register; while the receiver stalls, the
// next request can still be taken and worked, and it waits for the slot.
// After reset every row is written all-used, one row per cycle, up to the
// last of the NUM_PAGES / MAP_WORD_BITS rows (rounded up); req_ready stays low.
module bitmap_page_allocator_top #(
   parameter int NUM_PAGES     = bpa_pkg::NUM_PAGES_DEFAULT,
   parameter int MAP_WORD_BITS = bpa_pkg::MAP_WORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bpa_pkg::CMD_W-1:0]     req_cmd,
   input  logic [bpa_pkg::PAGE_W-1:0]    req_page,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bpa_pkg::PAGE_W-1:0]    rsp_result_page,
   output logic                          rsp_status,
   input  logic                          csr_wr_en,
   input  logic [bpa_pkg::LIMIT_W-1:0]   csr_wr_data
);

   bpa_pkg::ctrl_cmd_type  cmd;
   bpa_pkg::dp_status_type status;

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bpa_datapath #(
      .NUM_PAGES     (NUM_PAGES),
      .MAP_WORD_BITS (MAP_WORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_page        (req_page),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_page (rsp_result_page),
      .rsp_status      (rsp_status),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

>>> hdl/bpa_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module bpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/bpa_ctrl.sv
// Sequencer for clear, allocate scan, free/reserve and response hand-off.
module bpa_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [bpa_pkg::CMD_W-1:0]   req_cmd,
   output logic                        req_ready,
   input  bpa_pkg::dp_status_type      status,
   output bpa_pkg::ctrl_cmd_type       cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_START,
      ST_A_SCAN,
      ST_A_HIT,
      ST_F_RD,
      ST_F_WR,
      ST_ECHO,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (req_cmd == bpa_pkg::CMD_ALLOC) begin
                  state_in = ST_A_START;
               end else if (req_cmd == bpa_pkg::CMD_FREE ||
                            req_cmd == bpa_pkg::CMD_RESERVE) begin
                  state_in = ST_F_RD;
               end else begin
                  state_in = ST_ECHO;
               end
            end
         end
         ST_A_START: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_A_SCAN;
         end
         ST_A_SCAN: begin
            // row data belongs to the word counter; next row is fetched ahead
            if (status.base_ge_lim) begin
               cmd.res_fail = 1'b1;
               state_in     = ST_DONE;
            end else if (status.word_full) begin
               cmd.scan_adv = 1'b1;
               cmd.rd_en    = 1'b1;
               cmd.rd_next  = 1'b1;
            end else begin
               cmd.scan_capture = 1'b1;
               state_in         = ST_A_HIT;
            end
         end
         ST_A_HIT: begin
            if (status.p_ge_lim) begin
               cmd.res_fail = 1'b1;
            end else begin
               cmd.wr_hit  = 1'b1;
               cmd.res_hit = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_F_RD: begin
            if (status.page_oob) begin
               cmd.res_echo = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_F_WR;
            end
         end
         ST_F_WR: begin
            cmd.wr_fr    = 1'b1;
            cmd.res_echo = 1'b1;
            state_in     = ST_DONE;
         end
         ST_ECHO: begin
            cmd.res_echo = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

>>> hdl/bpa_datapath.sv
// Map RAM, scan counters, free-bit finder, limit register, response register.
module bpa_datapath #(
   parameter int NUM_PAGES     = bpa_pkg::NUM_PAGES_DEFAULT,
   parameter int MAP_WORD_BITS = bpa_pkg::MAP_WORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bpa_pkg::CMD_W-1:0]     req_cmd,
   input  logic [bpa_pkg::PAGE_W-1:0]    req_page,
   input  logic                          csr_wr_en,
   input  logic [bpa_pkg::LIMIT_W-1:0]   csr_wr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bpa_pkg::PAGE_W-1:0]    rsp_result_page,
   output logic                          rsp_status,
   input  bpa_pkg::ctrl_cmd_type         cmd,
   output bpa_pkg::dp_status_type        status
);

   localparam int MAP_WORDS = (NUM_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W     = $clog2(MAP_WORD_BITS);
   localparam int CNT_W     = $clog2(NUM_PAGES + MAP_WORD_BITS + (1 << bpa_pkg::LIMIT_W));

   logic [bpa_pkg::LIMIT_W-1:0] limit_ff;
   logic [bpa_pkg::CMD_W-1:0]   cmd_ff;
   logic [bpa_pkg::PAGE_W-1:0]  page_ff;
   logic [AW-1:0]               word_ff;
   logic [CNT_W-1:0]            base_ff;
   logic [BIT_W-1:0]            rem_ff;
   logic [MAP_WORD_BITS-1:0]    row_ff;
   logic [MAP_WORD_BITS-1:0]    onehot_ff;
   logic [bpa_pkg::PAGE_W-1:0]  res_page_ff;
   logic                        res_status_ff;
   logic                        rsp_valid_ff;
   logic [bpa_pkg::PAGE_W-1:0]  rsp_page_ff;
   logic                        rsp_status_ff;

   logic [CNT_W-1:0]            limit_ext;
   logic [CNT_W-1:0]            lim_eff;
   logic [MAP_WORD_BITS-1:0]    rd_data;
   logic [MAP_WORD_BITS-1:0]    first_free;
   logic [BIT_W-1:0]            hit_idx;
   logic [CNT_W-1:0]            hit_page;
   logic [MAP_WORD_BITS-1:0]    bit_mask;
   logic                        wr_en;
   logic [MAP_WORD_BITS-1:0]    wr_data;
   logic [AW-1:0]               rd_addr;

   assign limit_ext = CNT_W'(limit_ff);
   assign lim_eff   = (limit_ext > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : limit_ext;

   // lowest zero bit of the row as a one-hot mask
   assign first_free = ~rd_data & (rd_data + MAP_WORD_BITS'(1));

   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < MAP_WORD_BITS; i++) begin
         if (onehot_ff[i]) begin
            hit_idx = hit_idx | BIT_W'(i);
         end
      end
   end

   assign hit_page = base_ff + CNT_W'(hit_idx);
   assign bit_mask = MAP_WORD_BITS'(1) << rem_ff;

   always_comb begin
      wr_en   = cmd.clr_step | cmd.wr_hit | cmd.wr_fr;
      wr_data = {MAP_WORD_BITS{1'b1}};
      if (cmd.wr_hit) begin
         wr_data = row_ff | onehot_ff;
      end else if (cmd.wr_fr) begin
         wr_data = (cmd_ff == bpa_pkg::CMD_RESERVE) ? (rd_data | bit_mask)
                                                    : (rd_data & ~bit_mask);
      end
   end

   assign rd_addr = cmd.rd_next ? (word_ff + AW'(1)) : word_ff;

   bpa_ram #(
      .WIDTH (MAP_WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= bpa_pkg::LIMIT_RESET;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (cmd.load_req) begin
            // allocate scans from row 0; free and reserve go to the page's row
            // (MAP_WORD_BITS is a power of two, so the row is a slice)
            word_ff <= (req_cmd == bpa_pkg::CMD_ALLOC) ? '0 : AW'(req_page >> BIT_W);
         end else if (cmd.clr_step || cmd.scan_adv) begin
            word_ff <= word_ff + AW'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff  <= req_cmd;
         page_ff <= req_page;
         base_ff <= '0;
         rem_ff  <= req_page[BIT_W-1:0];
      end else begin
         if (cmd.scan_adv) begin
            base_ff <= base_ff + CNT_W'(MAP_WORD_BITS);
         end
      end
      if (cmd.scan_capture) begin
         row_ff    <= rd_data;
         onehot_ff <= first_free;
      end
      if (cmd.res_echo) begin
         res_page_ff   <= page_ff;
         res_status_ff <= 1'b0;
      end else if (cmd.res_fail) begin
         res_page_ff   <= '0;
         res_status_ff <= 1'b1;
      end else if (cmd.res_hit) begin
         res_page_ff   <= hit_page[bpa_pkg::PAGE_W-1:0];
         res_status_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_page_ff   <= res_page_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign status.clr_last    = (word_ff == AW'(MAP_WORDS - 1));
   assign status.base_ge_lim = (base_ff >= lim_eff);
   assign status.word_full   = (rd_data == {MAP_WORD_BITS{1'b1}});
   assign status.p_ge_lim    = (hit_page >= lim_eff);
   assign status.page_oob    = (CNT_W'(page_ff) >= CNT_W'(NUM_PAGES));
   assign status.rsp_free    = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_page = rsp_page_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

>>> hdl/bpa_checker.sv
// Port-level assertions for the allocator, bound to the top level.
module bpa_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [bpa_pkg::PAGE_W-1:0] rsp_result_page,
   input logic                       rsp_status
);

   // the map clear after reset blocks requests
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during map clear");

   // one request at a time: an accepted request closes the input
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one is in work");

   // out of memory always reports page zero
   a_fail_page_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_result_page == '0))
      else $error("out-of-memory response with nonzero page");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_result_page) && $stable(rsp_status)))
      else $error("stalled response changed");

endmodule

bind bitmap_page_allocator_top bpa_checker u_checker (.*);
